// ===== design/assert_macros.svh =====
// Assertion helpers used by two_zone_crossing_counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge outside reset.
`define ZTC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ZTC_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/ztc_pkg.sv =====
// ----------------------------------------------------------------------------
// ztc_pkg
// Types and constants for the two-zone crossing counter.
// ----------------------------------------------------------------------------
package ztc_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int MAX_COAST_DEF   = 1;
    localparam int MIN_HITS_DEF    = 3;
    localparam int AGE_LIMIT_DEF   = 30;

    localparam int IDX_W   = (TABLE_DEPTH_DEF > 1) ? $clog2(TABLE_DEPTH_DEF) : 1;
    localparam int ID_W    = 16;
    localparam int AGE_W   = 8;
    localparam int CNT_W   = 32;
    localparam int COORD_W = 12;
    localparam int NUM_REGS = 8;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_INS,
        OP_CLR,
        OP_INC
    } entry_op_t;

    typedef enum logic [2:0] {
        REG_A_X,
        REG_A_Y,
        REG_A_W,
        REG_A_H,
        REG_B_X,
        REG_B_Y,
        REG_B_W,
        REG_B_H
    } reg_idx_t;

    typedef struct packed {
        logic              vld;
        logic [ID_W-1:0]   id;
        logic              fa;
        logic [IDX_W-1:0]  ia;
        logic [AGE_W-1:0]  a_age;
        logic              fb;
        logic [IDX_W-1:0]  ib;
        logic [AGE_W-1:0]  b_age;
        logic              hfa;
        logic [IDX_W-1:0]  fra;
        logic              hfb;
        logic [IDX_W-1:0]  frb;
    } scan_rec_t;

    typedef struct packed {
        entry_op_t         a_op;
        logic [IDX_W-1:0]  a_idx;
        entry_op_t         b_op;
        logic [IDX_W-1:0]  b_idx;
        logic [ID_W-1:0]   id;
    } entry_cmd_t;

endpackage

// ===== design/ztc_cell.sv =====
// ----------------------------------------------------------------------------
// ztc_cell
// One entry of both zone tables; passes the lookup request to its neighbor.
// ----------------------------------------------------------------------------
module ztc_cell #(
    parameter int IDX = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ztc_pkg::scan_rec_t  rec_in,
    output ztc_pkg::scan_rec_t  rec_out,
    input  ztc_pkg::entry_cmd_t cmd
);

    localparam logic [ztc_pkg::IDX_W-1:0] MY_IDX = ztc_pkg::IDX_W'(IDX);

    logic                        a_valid_reg;
    logic [ztc_pkg::ID_W-1:0]    a_ident_reg;
    logic [ztc_pkg::AGE_W-1:0]   a_age_reg;
    logic                        b_valid_reg;
    logic [ztc_pkg::ID_W-1:0]    b_ident_reg;
    logic [ztc_pkg::AGE_W-1:0]   b_age_reg;
    ztc_pkg::scan_rec_t          rec_reg;
    ztc_pkg::scan_rec_t          rec_next;

    always_comb begin
        rec_next = rec_in;
        if (a_valid_reg && a_ident_reg == rec_in.id && !rec_in.fa) begin
            rec_next.fa    = 1'b1;
            rec_next.ia    = MY_IDX;
            rec_next.a_age = a_age_reg;
        end
        if (!a_valid_reg && !rec_in.hfa) begin
            rec_next.hfa = 1'b1;
            rec_next.fra = MY_IDX;
        end
        if (b_valid_reg && b_ident_reg == rec_in.id && !rec_in.fb) begin
            rec_next.fb    = 1'b1;
            rec_next.ib    = MY_IDX;
            rec_next.b_age = b_age_reg;
        end
        if (!b_valid_reg && !rec_in.hfb) begin
            rec_next.hfb = 1'b1;
            rec_next.frb = MY_IDX;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.a_idx == MY_IDX) begin
            case (cmd.a_op)
                ztc_pkg::OP_INS: begin
                    a_ident_reg <= cmd.id;
                    a_age_reg   <= '0;
                end
                ztc_pkg::OP_INC: a_age_reg <= a_age_reg + 1'b1;
                default: ;
            endcase
        end
        if (cmd.b_idx == MY_IDX) begin
            case (cmd.b_op)
                ztc_pkg::OP_INS: begin
                    b_ident_reg <= cmd.id;
                    b_age_reg   <= '0;
                end
                ztc_pkg::OP_INC: b_age_reg <= b_age_reg + 1'b1;
                default: ;
            endcase
        end
        if (!aresetn) begin
            rec_reg.vld <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            rec_reg <= rec_next;
            if (cmd.a_idx == MY_IDX && cmd.a_op == ztc_pkg::OP_INS) begin
                a_valid_reg <= 1'b1;
            end else if (cmd.a_idx == MY_IDX && cmd.a_op == ztc_pkg::OP_CLR) begin
                a_valid_reg <= 1'b0;
            end
            if (cmd.b_idx == MY_IDX && cmd.b_op == ztc_pkg::OP_INS) begin
                b_valid_reg <= 1'b1;
            end else if (cmd.b_idx == MY_IDX && cmd.b_op == ztc_pkg::OP_CLR) begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    assign rec_out = rec_reg;

endmodule

// ===== design/two_zone_crossing_counter.sv =====
// ----------------------------------------------------------------------------
// two_zone_crossing_counter
// Counts tracked objects that move from zone A into zone B.
// ----------------------------------------------------------------------------
// Input channel s_*: one tracked object per request (id, quality, box).
// Output channel m_*: one result per request (running count and flags).
// APB port: eight 12-bit zone registers at byte addresses 0x00..0x1C.
// Each request walks a chain of TABLE_DEPTH cells, one cell per cycle, which
// hold one A entry and one B entry each; the walk finds the object's entries
// and the lowest free ones. When the walk ends, the table command is latched
// in cmd_reg; in ST_WRITE it is applied to the cells, and the result register
// loads there unless the receiver stalls. A new request is not taken before
// the previous one has finished its walk and table update.
// s_tready is high only while no request is in work; a new request may be
// taken while the previous result still waits in the output register.
// A stalled receiver holds the result; the next request still finishes its
// walk and table update, then waits to load its result.
// Reset clears all table entries, the count and both channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module two_zone_crossing_counter #(
    parameter int MAX_COAST   = ztc_pkg::MAX_COAST_DEF,
    parameter int MIN_HITS    = ztc_pkg::MIN_HITS_DEF,
    parameter int AGE_LIMIT   = ztc_pkg::AGE_LIMIT_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // object_id[15:0] coast_frames[23:16] hit_run[31:24] frame_number[47:32]
    // box_left[60:48] box_top[73:61] box_width[85:74] box_height[97:86]
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // total_count[31:0] counted_now[32] table_full[33]
    output logic [39:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int CW = ztc_pkg::COORD_W;
    localparam int TABLE_DEPTH = ztc_pkg::TABLE_DEPTH_DEF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

    state_t                      state_reg;
    logic [CW-1:0]               zone_reg [ztc_pkg::NUM_REGS];
    logic [ztc_pkg::CNT_W-1:0]   count_reg;
    logic                        qual_reg;
    logic                        in_a_reg;
    logic                        in_b_reg;
    logic                        counted_reg;
    logic                        full_reg;
    logic                        m_tvalid_reg;
    logic [39:0]                 m_tdata_reg;
    ztc_pkg::entry_cmd_t         cmd_reg;
    ztc_pkg::entry_cmd_t         cmd_next;
    ztc_pkg::scan_rec_t          rec_head;
    ztc_pkg::scan_rec_t          rec_chain [TABLE_DEPTH+1];
    ztc_pkg::scan_rec_t          rec_last;

    logic [ztc_pkg::ID_W-1:0]    in_id;
    logic [7:0]                  in_coast;
    logic [7:0]                  in_hits;
    logic [15:0]                 in_frame;
    logic signed [14:0]          bx, by, bx2, by2;
    logic signed [14:0]          ax1, ay1, ax2, ay2, bzx1, bzy1, bzx2, bzy2;
    logic                        qual, in_a, in_b;
    logic                        accept, cfg_wr;
    logic                        done_a, done_b, counted_next, full_next;
    logic [ztc_pkg::AGE_W-1:0]   a_age_inc;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = {{(32-CW){1'b0}}, zone_reg[paddr[4:2]]};

    assign in_id    = s_tdata[15:0];
    assign in_coast = s_tdata[23:16];
    assign in_hits  = s_tdata[31:24];
    assign in_frame = s_tdata[47:32];
    assign bx  = 15'(signed'(s_tdata[60:48]));
    assign by  = 15'(signed'(s_tdata[73:61]));
    assign bx2 = bx + signed'({3'b000, s_tdata[85:74]});
    assign by2 = by + signed'({3'b000, s_tdata[97:86]});

    assign qual = (in_coast < 8'(MAX_COAST))
                && ((in_hits >= 8'(MIN_HITS)) || (in_frame < 16'(MIN_HITS)));

    always_comb begin
        ax1  = signed'({3'b000, zone_reg[ztc_pkg::REG_A_X]});
        ay1  = signed'({3'b000, zone_reg[ztc_pkg::REG_A_Y]});
        ax2  = ax1 + signed'({3'b000, zone_reg[ztc_pkg::REG_A_W]});
        ay2  = ay1 + signed'({3'b000, zone_reg[ztc_pkg::REG_A_H]});
        bzx1 = signed'({3'b000, zone_reg[ztc_pkg::REG_B_X]});
        bzy1 = signed'({3'b000, zone_reg[ztc_pkg::REG_B_Y]});
        bzx2 = bzx1 + signed'({3'b000, zone_reg[ztc_pkg::REG_B_W]});
        bzy2 = bzy1 + signed'({3'b000, zone_reg[ztc_pkg::REG_B_H]});
        in_a = ((ax2 < bx2 ? ax2 : bx2) > (ax1 > bx ? ax1 : bx))
            && ((ay2 < by2 ? ay2 : by2) > (ay1 > by ? ay1 : by));
        in_b = ((bzx2 < bx2 ? bzx2 : bx2) > (bzx1 > bx ? bzx1 : bx))
            && ((bzy2 < by2 ? bzy2 : by2) > (bzy1 > by ? bzy1 : by));
    end

    always_comb begin
        rec_head     = '0;
        rec_head.vld = accept;
        rec_head.id  = in_id;
    end

    assign rec_chain[0] = rec_head;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        ztc_cell #(
            .IDX(g)
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .rec_in (rec_chain[g]),
            .rec_out(rec_chain[g+1]),
            .cmd    (cmd_reg)
        );
    end

    assign rec_last = rec_chain[TABLE_DEPTH];

    always_comb begin
        cmd_next       = '0;
        cmd_next.id    = rec_last.id;
        cmd_next.a_idx = rec_last.fa ? rec_last.ia : rec_last.fra;
        cmd_next.b_idx = rec_last.fb ? rec_last.ib : rec_last.frb;
        counted_next   = 1'b0;
        full_next      = 1'b0;
        a_age_inc      = rec_last.a_age + 1'b1;
        done_a         = !qual_reg || (in_a_reg && in_b_reg);
        done_b         = done_a;
        if (!done_a) begin
            if (!rec_last.fa) begin
                if (in_a_reg) begin
                    if (rec_last.hfa) begin
                        cmd_next.a_op = ztc_pkg::OP_INS;
                    end else begin
                        full_next = 1'b1;
                    end
                end
            end else if (rec_last.a_age >= ztc_pkg::AGE_W'(AGE_LIMIT)) begin
                cmd_next.a_op = ztc_pkg::OP_CLR;
                done_b = 1'b1;
            end else begin
                cmd_next.a_op = ztc_pkg::OP_INC;
            end
        end
        if (!done_b) begin
            if (!rec_last.fb) begin
                if (in_b_reg) begin
                    if (rec_last.hfb) begin
                        cmd_next.b_op = ztc_pkg::OP_INS;
                    end else begin
                        full_next = 1'b1;
                    end
                end
            end else if (rec_last.fa) begin
                if (rec_last.b_age <= a_age_inc) begin
                    cmd_next.a_op = ztc_pkg::OP_CLR;
                    cmd_next.b_op = ztc_pkg::OP_CLR;
                    counted_next  = 1'b1;
                end
            end else if (rec_last.b_age >= ztc_pkg::AGE_W'(AGE_LIMIT)) begin
                cmd_next.b_op = ztc_pkg::OP_CLR;
            end else begin
                cmd_next.b_op = ztc_pkg::OP_INC;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            qual_reg <= qual;
            in_a_reg <= in_a;
            in_b_reg <= in_b;
        end
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            cmd_reg      <= '0;
            for (int i = 0; i < ztc_pkg::NUM_REGS; i++) begin
                zone_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                zone_reg[paddr[4:2]] <= pwdata[CW-1:0];
            end
            cmd_reg <= (state_reg == ST_SCAN && rec_last.vld) ? cmd_next : '0;
            if (state_reg == ST_WRITE && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (rec_last.vld) begin
                        counted_reg <= counted_next;
                        full_reg    <= full_next;
                        count_reg   <= count_reg + ztc_pkg::CNT_W'(counted_next);
                        state_reg   <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {6'b000000, full_reg, counted_reg, count_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ZTC_NEVER(a_scan_only_busy, aclk, aresetn, rec_last.vld && state_reg != ST_SCAN,
        "lookup request left the chain outside a scan")
    `ZTC_NEVER(a_count_or_full, aclk, aresetn, m_tvalid && m_tdata[32] && m_tdata[33],
        "crossing and dropped insert in one result")
    `ZTC_ASSERT(a_count_step, aclk, aresetn,
        count_reg != $past(count_reg) |-> $past(state_reg == ST_SCAN),
        "count changed outside scan completion")

endmodule
